// ----- hw/rtl/rppg_pkg.sv -----
`default_nettype none
package rppg_pkg;

  localparam int MAX_SIDE     = 4096;
  localparam int CORDIC_STEPS = 20;

  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int PIX_W     = 24;
  localparam int PHASE_W   = 13;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 13;
  localparam int X_W       = SIDE_W + 1;
  localparam int Y_W       = PIX_W + 1;
  localparam int SQ_W      = 2 * PIX_W + 2;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int GEO_STEPS = ROOT_W;
  localparam int GEO_IDX_W = $clog2(GEO_STEPS);
  localparam int CORD_PRE  = 24;
  localparam int CORD_W    = Y_W + CORD_PRE + 2;
  localparam int Z_W       = 22;
  localparam int TURN_W    = 21;
  localparam int TURN_ONE  = 1 << 20;
  localparam int POS_W     = ROOT_W;
  localparam int SCALE_NUM = 33423;
  localparam int SCALE_W   = 16;
  localparam int PROD_W    = SIDE_W + SCALE_W;
  localparam int LATENCY   = 1 + PIX_W + 2 + GEO_STEPS + 5;

  localparam logic [MODE_W-1:0] MODE_CORNER  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RADIAL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ANGULAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE2 = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0]  num;
    logic [SIDE_W-1:0] rem;
    logic [PIX_W-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic [SQ_W-1:0]          n;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
    logic signed [CORD_W-1:0] a;
    logic signed [CORD_W-1:0] b;
    logic signed [Z_W-1:0]    z;
    logic [TURN_W-1:0]        off;
    logic                     spec;
    logic [TURN_W-1:0]        specf;
    logic [PIX_W-1:0]         cpos;
  } geo_t;

  typedef struct packed {
    logic                dpos;
    logic [SIDE_W-1:0]   dval;
  } shade_t;

  function automatic logic signed [Z_W-1:0] turn_angle(input logic [GEO_IDX_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = 22'sd131072;
      5'd1:  v = 22'sd77376;
      5'd2:  v = 22'sd40884;
      5'd3:  v = 22'sd20753;
      5'd4:  v = 22'sd10417;
      5'd5:  v = 22'sd5213;
      5'd6:  v = 22'sd2607;
      5'd7:  v = 22'sd1304;
      5'd8:  v = 22'sd652;
      5'd9:  v = 22'sd326;
      5'd10: v = 22'sd163;
      5'd11: v = 22'sd81;
      5'd12: v = 22'sd41;
      5'd13: v = 22'sd20;
      5'd14: v = 22'sd10;
      5'd15: v = 22'sd5;
      5'd16: v = 22'sd3;
      5'd17: v = 22'sd1;
      5'd18: v = 22'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic shade_t shade(input logic [POS_W-1:0] pos,
                                   input logic [PHASE_W-1:0] phase,
                                   input logic [SIDE_W-1:0] side);
    logic signed [POS_W+1:0] diff;
    logic [POS_W+1:0]        mag;
    logic signed [POS_W+2:0] d;
    shade_t s;
    diff = $signed({2'b00, POS_W'(phase)}) - $signed({2'b00, pos});
    mag  = diff[POS_W+1] ? (POS_W+2)'(-diff) : diff;
    d    = $signed({3'b000, POS_W'(side)}) - $signed({1'b0, mag});
    s.dpos = !d[POS_W+2] && (d != '0);
    s.dval = d[SIDE_W-1:0];
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rppg_div_cell.sv -----
`default_nettype none
module rppg_div_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [rppg_pkg::SIDE_W-1:0]  side,
  input  wire logic                         v_in,
  input  wire rppg_pkg::div_t               d_in,
  output logic                              v_out,
  output rppg_pkg::div_t                    d_out
);

  logic                        v_r;
  rppg_pkg::div_t              d_r, d_nxt;
  logic [rppg_pkg::SIDE_W:0]   trial;
  logic                        ge;

  always_comb begin
    trial = {d_in.rem, d_in.num[rppg_pkg::PIX_W-1]};
    ge    = trial >= {1'b0, side};
    d_nxt.num = d_in.num << 1;
    d_nxt.rem = ge ? rppg_pkg::SIDE_W'(trial - {1'b0, side}) : trial[rppg_pkg::SIDE_W-1:0];
    d_nxt.quo = {d_in.quo[rppg_pkg::PIX_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    d_r <= d_nxt;
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rppg_geo_cell.sv -----
`default_nettype none
module rppg_geo_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [rppg_pkg::GEO_IDX_W-1:0] idx,
  input  wire logic                           v_in,
  input  wire rppg_pkg::geo_t                 d_in,
  output logic                                v_out,
  output rppg_pkg::geo_t                      d_out
);

  logic                                   v_r;
  rppg_pkg::geo_t                         d_r, d_nxt;
  logic [rppg_pkg::REM_W+1:0]             rem_sh;
  logic [rppg_pkg::REM_W+1:0]             trial;
  logic signed [rppg_pkg::CORD_W-1:0]     da, db;
  logic                                   active;

  always_comb begin
    d_nxt  = d_in;
    // square root digit
    rem_sh = {d_in.rem, d_in.n[rppg_pkg::SQ_W-1 -: 2]};
    trial  = {2'b00, d_in.root, 2'b01};
    d_nxt.n = d_in.n << 2;
    if (rem_sh >= trial) begin
      d_nxt.rem  = rppg_pkg::REM_W'(rem_sh - trial);
      d_nxt.root = {d_in.root[rppg_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh[rppg_pkg::REM_W-1:0];
      d_nxt.root = {d_in.root[rppg_pkg::ROOT_W-2:0], 1'b0};
    end
    // cordic rotation
    active = (int'(idx) < rppg_pkg::CORDIC_STEPS) && !d_in.spec;
    da = d_in.b >>> idx;
    db = d_in.a >>> idx;
    if (active) begin
      if (!d_in.b[rppg_pkg::CORD_W-1]) begin
        d_nxt.a = d_in.a + da;
        d_nxt.b = d_in.b - db;
        d_nxt.z = d_in.z + rppg_pkg::turn_angle(idx);
      end else begin
        d_nxt.a = d_in.a - da;
        d_nxt.b = d_in.b + db;
        d_nxt.z = d_in.z - rppg_pkg::turn_angle(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    d_r <= d_nxt;
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rainbow_pattern_pixel_generator_core.sv -----
`default_nettype none
// Rainbow test-pattern pixel generator. A pixel number is taken whenever start is high
// (busy is always low), one per clock, and its color bytes appear on the out_ ports
// with out_strobe high for a single cycle; results cannot be held off. The pipeline
// is a 24-cell restoring divider that splits the pixel number into row and column, a
// 25-cell chain that runs the square root digits and the cordic rotations side by side,
// and eight stages of input, setup, scaling and shading.
// Configuration writes take effect at once and must only be made while no pixel is
// in flight.
module rainbow_pattern_pixel_generator_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [rppg_pkg::PIX_W-1:0]      in_pixel_index,
  output logic                                 out_strobe,
  output logic [7:0]                           out_chan_first,
  output logic [7:0]                           out_chan_second,
  output logic [7:0]                           out_chan_third,
  output logic                                 out_outside_circle,
  input  wire logic                            cfg_we,
  input  wire logic [rppg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rppg_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int PIX_W  = rppg_pkg::PIX_W;
  localparam int SIDE_W = rppg_pkg::SIDE_W;
  localparam int POS_W  = rppg_pkg::POS_W;
  localparam int TURN_W = rppg_pkg::TURN_W;
  localparam int MUL_W  = TURN_W + SIDE_W;

  logic [rppg_pkg::MODE_W-1:0]  mode_r;
  logic [SIDE_W-1:0]            side_cfg_r;
  logic [rppg_pkg::PHASE_W-1:0] phase0_r, phase1_r, phase2_r;
  logic [SIDE_W-1:0]            side;
  logic                         accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= rppg_pkg::MODE_ANGULAR;
      side_cfg_r <= 13'd500;
      phase0_r   <= 13'd500;
      phase1_r   <= 13'd250;
      phase2_r   <= 13'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rppg_pkg::REG_MODE:   mode_r     <= cfg_wdata[rppg_pkg::MODE_W-1:0];
        rppg_pkg::REG_SIDE:   side_cfg_r <= cfg_wdata[SIDE_W-1:0];
        rppg_pkg::REG_PHASE0: phase0_r   <= cfg_wdata[rppg_pkg::PHASE_W-1:0];
        rppg_pkg::REG_PHASE1: phase1_r   <= cfg_wdata[rppg_pkg::PHASE_W-1:0];
        rppg_pkg::REG_PHASE2: phase2_r   <= cfg_wdata[rppg_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (side_cfg_r < SIDE_W'(2)) begin
      side = SIDE_W'(2);
    end else if (side_cfg_r > SIDE_W'(rppg_pkg::MAX_SIDE)) begin
      side = SIDE_W'(rppg_pkg::MAX_SIDE);
    end else begin
      side = side_cfg_r;
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register and divider chain
  logic           div_v [PIX_W+1];
  rppg_pkg::div_t div_d [PIX_W+1];
  logic           s0_v_r;
  logic [PIX_W-1:0] s0_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= accept;
    end
    s0_pix_r <= in_pixel_index;
  end

  assign div_v[0]     = s0_v_r;
  assign div_d[0].num = s0_pix_r;
  assign div_d[0].rem = '0;
  assign div_d[0].quo = '0;

  for (genvar k = 0; k < PIX_W; k++) begin : g_div
    rppg_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .side  (side),
      .v_in  (div_v[k]),
      .d_in  (div_d[k]),
      .v_out (div_v[k+1]),
      .d_out (div_d[k+1])
    );
  end

  // centered coordinates
  logic                            p1_v_r;
  logic signed [rppg_pkg::X_W-1:0] p1_x_r;
  logic signed [rppg_pkg::Y_W-1:0] p1_y_r;
  logic [PIX_W-1:0]                p1_cpos_r;
  logic [SIDE_W-1:0]               half;
  logic [PIX_W:0]                  csum;

  always_comb begin
    half = side >> 1;
    csum = (PIX_W+1)'(div_d[PIX_W].rem) + (PIX_W+1)'(div_d[PIX_W].quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= div_v[PIX_W];
    end
    p1_x_r    <= $signed({1'b0, div_d[PIX_W].rem}) - $signed({1'b0, half});
    p1_y_r    <= $signed({1'b0, div_d[PIX_W].quo}) - $signed(rppg_pkg::Y_W'(half));
    p1_cpos_r <= csum[PIX_W:1];
  end

  // squares and cordic setup
  logic                                  p2_v_r;
  rppg_pkg::geo_t                        p2_d_r, p2_d_nxt;
  logic signed [2*rppg_pkg::X_W-1:0]     xx;
  logic signed [2*rppg_pkg::Y_W-1:0]     yy;
  logic [rppg_pkg::SQ_W-1:0]             sq;
  logic                                  yneg;
  logic [rppg_pkg::Y_W-1:0]              ymag;
  logic signed [rppg_pkg::X_W-1:0]       xs;

  always_comb begin
    xx   = p1_x_r * p1_x_r;
    yy   = p1_y_r * p1_y_r;
    sq   = rppg_pkg::SQ_W'($unsigned(yy)) + rppg_pkg::SQ_W'($unsigned(xx));
    yneg = p1_y_r[rppg_pkg::Y_W-1];
    ymag = yneg ? rppg_pkg::Y_W'(-p1_y_r) : p1_y_r;
    xs   = yneg ? rppg_pkg::X_W'(-p1_x_r) : p1_x_r;
    p2_d_nxt.n    = sq << 2;
    p2_d_nxt.rem  = '0;
    p2_d_nxt.root = '0;
    p2_d_nxt.a    = $signed(rppg_pkg::CORD_W'(ymag)) <<< rppg_pkg::CORD_PRE;
    p2_d_nxt.b    = rppg_pkg::CORD_W'(xs) <<< rppg_pkg::CORD_PRE;
    p2_d_nxt.z    = '0;
    p2_d_nxt.cpos = p1_cpos_r;
    priority if (!yneg) begin
      p2_d_nxt.off = TURN_W'(rppg_pkg::TURN_ONE / 2);
    end else if (!p1_x_r[rppg_pkg::X_W-1]) begin
      p2_d_nxt.off = TURN_W'(rppg_pkg::TURN_ONE);
    end else begin
      p2_d_nxt.off = '0;
    end
    p2_d_nxt.spec = (p1_x_r == '0) || (p1_y_r == '0);
    priority if (p1_x_r == '0) begin
      p2_d_nxt.specf = yneg ? TURN_W'(rppg_pkg::TURN_ONE) : TURN_W'(rppg_pkg::TURN_ONE / 2);
    end else if (!p1_x_r[rppg_pkg::X_W-1]) begin
      p2_d_nxt.specf = TURN_W'((rppg_pkg::TURN_ONE / 4) * 3);
    end else begin
      p2_d_nxt.specf = TURN_W'(rppg_pkg::TURN_ONE / 4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else begin
      p2_v_r <= p1_v_r;
    end
    p2_d_r <= p2_d_nxt;
  end

  // square root and cordic chain
  logic           geo_v [rppg_pkg::GEO_STEPS+1];
  rppg_pkg::geo_t geo_d [rppg_pkg::GEO_STEPS+1];

  assign geo_v[0] = p2_v_r;
  assign geo_d[0] = p2_d_r;

  for (genvar g = 0; g < rppg_pkg::GEO_STEPS; g++) begin : g_geo
    rppg_geo_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (rppg_pkg::GEO_IDX_W'(g)),
      .v_in  (geo_v[g]),
      .d_in  (geo_d[g]),
      .v_out (geo_v[g+1]),
      .d_out (geo_d[g+1])
    );
  end

  // turn fraction
  rppg_pkg::geo_t                 ge;
  logic signed [rppg_pkg::Z_W:0]  fsum;
  logic [TURN_W-1:0]              fcl;
  logic                           p3_v_r;
  logic [TURN_W-1:0]              p3_f_r;
  logic [rppg_pkg::ROOT_W-1:0]    p3_root_r;
  logic [PIX_W-1:0]               p3_cpos_r;

  always_comb begin
    ge   = geo_d[rppg_pkg::GEO_STEPS];
    fsum = (rppg_pkg::Z_W+1)'(ge.z) + $signed({2'b00, ge.off});
    priority if (ge.spec) begin
      fcl = ge.specf;
    end else if (fsum[rppg_pkg::Z_W]) begin
      fcl = '0;
    end else if (fsum > $signed((rppg_pkg::Z_W+1)'(rppg_pkg::TURN_ONE))) begin
      fcl = TURN_W'(rppg_pkg::TURN_ONE);
    end else begin
      fcl = fsum[TURN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else begin
      p3_v_r <= geo_v[rppg_pkg::GEO_STEPS];
    end
    p3_f_r    <= fcl;
    p3_root_r <= ge.root;
    p3_cpos_r <= ge.cpos;
  end

  // angular scaling
  logic                        p4_v_r;
  logic [MUL_W-1:0]            p4_prod_r;
  logic [rppg_pkg::ROOT_W-1:0] p4_root_r;
  logic [PIX_W-1:0]            p4_cpos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else begin
      p4_v_r <= p3_v_r;
    end
    p4_prod_r <= MUL_W'(p3_f_r) * MUL_W'(side);
    p4_root_r <= p3_root_r;
    p4_cpos_r <= p3_cpos_r;
  end

  // position select and channel distance
  logic [POS_W-1:0]  pos;
  logic              outside;
  logic              p5_v_r, p5_out_r;
  rppg_pkg::shade_t  p5_s0_r, p5_s1_r, p5_s2_r;

  always_comb begin
    priority if (mode_r == rppg_pkg::MODE_CORNER) begin
      pos = POS_W'(p4_cpos_r);
    end else if (mode_r == rppg_pkg::MODE_RADIAL) begin
      pos = POS_W'(p4_root_r);
    end else begin
      pos = POS_W'(p4_prod_r[MUL_W-1:20]);
    end
    outside = (mode_r != rppg_pkg::MODE_CORNER) && (pos > POS_W'(side));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else begin
      p5_v_r <= p4_v_r;
    end
    p5_out_r <= outside;
    p5_s0_r  <= rppg_pkg::shade(pos, phase0_r, side);
    p5_s1_r  <= rppg_pkg::shade(pos, phase1_r, side);
    p5_s2_r  <= rppg_pkg::shade(pos, phase2_r, side);
  end

  // channel scaling
  logic                          p6_v_r, p6_out_r;
  logic [2:0]                    p6_dpos_r;
  logic [rppg_pkg::PROD_W-1:0]   p6_m0_r, p6_m1_r, p6_m2_r;
  localparam logic [rppg_pkg::PROD_W-1:0] SCALE = rppg_pkg::PROD_W'(rppg_pkg::SCALE_NUM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_v_r <= 1'b0;
    end else begin
      p6_v_r <= p5_v_r;
    end
    p6_out_r  <= p5_out_r;
    p6_dpos_r <= {p5_s2_r.dpos, p5_s1_r.dpos, p5_s0_r.dpos};
    p6_m0_r   <= rppg_pkg::PROD_W'(p5_s0_r.dval) * SCALE;
    p6_m1_r   <= rppg_pkg::PROD_W'(p5_s1_r.dval) * SCALE;
    p6_m2_r   <= rppg_pkg::PROD_W'(p5_s2_r.dval) * SCALE;
  end

  function automatic logic [7:0] clamp_byte(input logic dpos, input logic outs,
                                            input logic [rppg_pkg::PROD_W-1:0] m);
    logic [rppg_pkg::PROD_W-rppg_pkg::SCALE_W-1:0] v;
    logic [7:0] r;
    v = m[rppg_pkg::PROD_W-1:rppg_pkg::SCALE_W];
    priority if (outs) begin
      r = 8'hff;
    end else if (!dpos) begin
      r = 8'h00;
    end else if (v > (rppg_pkg::PROD_W-rppg_pkg::SCALE_W)'(255)) begin
      r = 8'hff;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  logic       p7_v_r, p7_out_r;
  logic [7:0] p7_c0_r, p7_c1_r, p7_c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_v_r <= 1'b0;
    end else begin
      p7_v_r <= p6_v_r;
    end
    p7_out_r <= p6_out_r;
    p7_c0_r  <= clamp_byte(p6_dpos_r[0], p6_out_r, p6_m0_r);
    p7_c1_r  <= clamp_byte(p6_dpos_r[1], p6_out_r, p6_m1_r);
    p7_c2_r  <= clamp_byte(p6_dpos_r[2], p6_out_r, p6_m2_r);
  end

  assign out_strobe         = p7_v_r;
  assign out_chan_first     = p7_c0_r;
  assign out_chan_second    = p7_c1_r;
  assign out_chan_third     = p7_c2_r;
  assign out_outside_circle = p7_out_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(rppg_pkg::LATENCY) out_strobe)
    else $error("word lost in pipeline");

  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_outside_circle) |->
      (out_chan_first == 8'hff && out_chan_second == 8'hff && out_chan_third == 8'hff))
    else $error("outside word not white");

  a_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && mode_r == rppg_pkg::MODE_CORNER) |-> !out_outside_circle)
    else $error("outside flag in cornered mode");
`endif

endmodule
`default_nettype wire

// ----- sim/rainbow_pattern_pixel_generator_core_test.sv -----
`timescale 1ns / 1ps
module rainbow_pattern_pixel_generator_core_test;
  import rppg_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST = 3'd7;
  localparam longint TURN = 64'sd1048576;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic       outside;
  } color_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    int                 side;
    int                 ph0;
    int                 ph1;
    int                 ph2;
    logic [PIX_W-1:0]   pix;
    int                 known;
    color_t             want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PIX_W-1:0] in_pixel_index = '0;
  logic out_strobe;
  logic [7:0] out_chan_first, out_chan_second, out_chan_third;
  logic out_outside_circle;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  rainbow_pattern_pixel_generator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_index(in_pixel_index), .out_strobe(out_strobe),
    .out_chan_first(out_chan_first), .out_chan_second(out_chan_second),
    .out_chan_third(out_chan_third), .out_outside_circle(out_outside_circle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [MODE_W-1:0] cur_mode = MODE_ANGULAR;
  logic [CFG_W-1:0] cur_side = 13'd500;
  logic [CFG_W-1:0] cur_phase [3] = '{13'd500, 13'd250, 13'd0};
  color_t pending_colors [$];
  int fail_count = 0;
  int cycles = 0;
  int idle_pct = 0;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint turn_of(longint x, longint y);
    longint angles [24] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                            652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0};
    longint a, b, z, off, f, da, db;
    if (x == 0) return (y < 0) ? TURN : TURN / 2;
    if (y == 0) return (x > 0) ? (TURN / 4) * 3 : TURN / 4;
    a = y * 64'sd16777216;
    b = x * 64'sd16777216;
    z = 0;
    if (a < 0) begin
      a = -a;
      b = -b;
      off = (x >= 0) ? TURN : 0;
    end else begin
      off = TURN / 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a = a + da;
        b = b - db;
        z = z + angles[i];
      end else begin
        a = a - da;
        b = b + db;
        z = z - angles[i];
      end
    end
    f = z + off;
    if (f < 0) f = 0;
    if (f > TURN) f = TURN;
    return f;
  endfunction

  function automatic logic [7:0] shade_of(longint side, longint phase, longint pos);
    longint diff = phase - pos;
    longint d, v;
    if (diff < 0) diff = -diff;
    d = side - diff;
    if (d <= 0) return 8'd0;
    v = (d * SCALE_NUM) >>> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic color_t pixel_color(logic [PIX_W-1:0] pix_in);
    longint side = cur_side;
    longint pix = pix_in;
    longint col, row, pos, x, y;
    color_t c;
    if (side < 2) side = 2;
    if (side > MAX_SIDE) side = MAX_SIDE;
    col = pix % side;
    row = pix / side;
    if (cur_mode == MODE_CORNER) begin
      pos = (col + row) / 2;
    end else begin
      x = col - side / 2;
      y = row - side / 2;
      if (cur_mode == MODE_RADIAL) pos = longint'(root_floor(4 * (x * x + y * y)));
      else pos = (turn_of(x, y) * side) >>> 20;
      if (pos > side) return '{8'd255, 8'd255, 8'd255, 1'b1};
    end
    c.first = shade_of(side, cur_phase[0], pos);
    c.second = shade_of(side, cur_phase[1], pos);
    c.third = shade_of(side, cur_phase[2], pos);
    c.outside = 1'b0;
    return c;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    color_t w;
    if (rst_n && out_strobe) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected word: %0d %0d %0d %0d", out_chan_first, out_chan_second,
               out_chan_third, out_outside_circle);
        fail_count++;
      end else begin
        w = pending_colors.pop_front();
        if (out_chan_first !== w.first) begin
          $error("chan_first: expected %0d, got %0d", w.first, out_chan_first);
          fail_count++;
        end
        if (out_chan_second !== w.second) begin
          $error("chan_second: expected %0d, got %0d", w.second, out_chan_second);
          fail_count++;
        end
        if (out_chan_third !== w.third) begin
          $error("chan_third: expected %0d, got %0d", w.third, out_chan_third);
          fail_count++;
        end
        if (out_outside_circle !== w.outside) begin
          $error("outside_circle: expected %0d, got %0d", w.outside, out_outside_circle);
          fail_count++;
        end
      end
    end
  end

  // write enable is lowered by the caller after the last write of a burst
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MODE: cur_mode = val[MODE_W-1:0];
      REG_SIDE: cur_side = val;
      REG_PHASE0: cur_phase[0] = val;
      REG_PHASE1: cur_phase[1] = val;
      REG_PHASE2: cur_phase[2] = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic setup(logic [MODE_W-1:0] m, logic [CFG_W-1:0] s, logic [CFG_W-1:0] p0,
                       logic [CFG_W-1:0] p1, logic [CFG_W-1:0] p2);
    start <= 1'b0;
    drain();
    cfg_write(REG_MODE, {11'($urandom_range(0, 2047)), m});
    cfg_write(REG_SIDE, s);
    cfg_write(REG_PHASE0, p0);
    cfg_write(REG_PHASE1, p1);
    cfg_write(REG_PHASE2, p2);
    cfg_we <= 1'b0;
  endtask

  // start stays high across back-to-back words; lowered only for a gap
  task automatic send_pixel(logic [PIX_W-1:0] pix, bit known, color_t want);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_index <= pix;
    do @(posedge clk); while (busy);
    pending_colors.push_back(known ? want : pixel_color(pix));
  endtask

  row_t rows [$];
  color_t none_c = '0;
  logic [CFG_W-1:0] side_r;
  logic [PIX_W-1:0] pix_r;
  longint area;

  initial begin
    rows = '{
      '{MODE_ANGULAR, 500, 500, 250, 0, 24'd0, 0, '0},
      '{MODE_RADIAL, 500, 500, 250, 0, 24'd0, 1, '{8'd255, 8'd255, 8'd255, 1'b1}},
      '{MODE_CORNER, 500, 500, 250, 0, 24'd0, 1, '{8'd0, 8'd127, 8'd254, 1'b0}},
      '{MODE_CORNER, 500, 500, 250, 0, 24'hFFFFFF, 0, '0},
      '{MODE_RADIAL, 500, 500, 250, 0, 24'd125250, 0, '0},
      '{MODE_ANGULAR, 500, 500, 250, 0, 24'd125250, 0, '0},
      '{MODE_ANGULAR, 500, 500, 250, 0, 24'd250, 0, '0},
      '{MODE_ANGULAR, 500, 500, 250, 0, 24'd125000, 0, '0},
      '{MODE_ANGULAR, 500, 500, 250, 0, 24'd125499, 0, '0},
      '{MODE_ANGULAR, 500, 500, 250, 0, 24'd249750, 0, '0},
      '{MODE_ANGULAR, 500, 500, 250, 0, 24'd3333, 0, '0},
      '{MODE_SPARE, 500, 500, 250, 0, 24'd1234, 0, '0},
      '{MODE_SPARE, 500, 500, 250, 0, 24'd200000, 0, '0},
      '{MODE_CORNER, 0, 1, 0, 2, 24'd7, 0, '0},
      '{MODE_RADIAL, 1, 1, 0, 2, 24'd3, 0, '0},
      '{MODE_CORNER, 2, 8191, 0, 4096, 24'd5, 0, '0},
      '{MODE_ANGULAR, 2, 8191, 0, 4096, 24'hFFFFFF, 0, '0},
      '{MODE_RADIAL, 4096, 4096, 2048, 0, 24'd0, 0, '0},
      '{MODE_RADIAL, 4096, 4096, 2048, 0, 24'd8390656, 0, '0},
      '{MODE_ANGULAR, 8191, 8191, 4096, 0, 24'hFFFFFF, 0, '0},
      '{MODE_CORNER, 4097, 8191, 8191, 8191, 24'hAAAAAA, 0, '0},
      '{MODE_CORNER, 4096, 0, 4096, 8191, 24'h555555, 0, '0}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].mode != cur_mode || rows[i].side != int'(cur_side)
          || rows[i].ph0 != int'(cur_phase[0]) || rows[i].ph1 != int'(cur_phase[1])
          || rows[i].ph2 != int'(cur_phase[2]))
        setup(rows[i].mode, CFG_W'(rows[i].side), CFG_W'(rows[i].ph0),
              CFG_W'(rows[i].ph1), CFG_W'(rows[i].ph2));
      send_pixel(rows[i].pix, rows[i].known != 0, rows[i].want);
    end
    start <= 1'b0;
    drain();
    cfg_write(REG_UNUSED, 13'h1FFF);
    cfg_write(REG_LAST, 13'd0);
    cfg_we <= 1'b0;

    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = (seg < 2) ? 19 : (seg < 4) ? 83 : 0;
      if (seg == 0) side_r = 13'd4096;
      else if (seg == 1) side_r = 13'd2;
      else if ($urandom_range(0, 3) == 0) side_r = CFG_W'($urandom_range(0, 8191));
      else side_r = CFG_W'($urandom_range(2, 64));
      setup(MODE_W'($urandom_range(0, 3)), side_r, CFG_W'($urandom_range(0, 8191)),
            CFG_W'($urandom_range(0, 80)), CFG_W'($urandom_range(0, 40)));
      area = (side_r < 2) ? 4 : (side_r > MAX_SIDE) ? MAX_SIDE * MAX_SIDE
             : longint'(side_r) * side_r;
      for (int k = 0; k < 67; k++) begin
        if ($urandom_range(0, 4) == 0) pix_r = PIX_W'($urandom);
        else pix_r = PIX_W'($urandom_range(0,
                       int'((area > 24'hFFFFFF ? 24'hFFFFFF : area - 1))));
        send_pixel(pix_r, 0, none_c);
      end
    end
    start <= 1'b0;
    drain();
    if (fail_count == 0 && pending_colors.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
